/* hdl/mmg_pkg.sv */
// Shared constants and types for the min/max gray normalizer.
`default_nettype none
package mmg_pkg;

  // Default sample width.
  localparam int unsigned SAMPLE_BITS_DEF = 32;
  // Output gray level width.
  localparam int unsigned LEVEL_BITS = 8;
  // Entries in the queue between front and back (power of two).
  localparam int unsigned QUEUE_DEPTH = 2;
  // Quotient bits produced by the scaler, one per step.
  localparam int unsigned STEP_COUNT = 8;
  localparam int unsigned STEP_BITS = $clog2(STEP_COUNT);

  // Classification of a convert item, decided in the front.
  localparam int unsigned KIND_BITS = 2;
  typedef enum logic [KIND_BITS-1:0] {
    KIND_FLAT = 2'd0,  // max <= min: level 0, flat flag
    KIND_LOW  = 2'd1,  // sample below min: level 0
    KIND_HIGH = 2'd2,  // sample at or above max: level 255
    KIND_DIV  = 2'd3   // in range: scaled division
  } kind_e;

  // Saturated full-scale level.
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

endpackage : mmg_pkg
`default_nettype wire

/* hdl/mmg_if.sv */
// Handshake interfaces for the sample, result and configuration channels.
`default_nettype none
interface mmg_in_if #(
  parameter int unsigned SAMPLE_BITS = mmg_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic                          frame_start;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, operation, frame_start, sample, input ready);
  modport sink   (input valid, operation, frame_start, sample, output ready);
endinterface : mmg_in_if

interface mmg_out_if;
  logic                            valid;
  logic                            ready;
  logic [mmg_pkg::LEVEL_BITS-1:0]  level;
  logic                            flat_range;

  modport source (output valid, level, flat_range, input ready);
  modport sink   (input valid, level, flat_range, output ready);
endinterface : mmg_out_if

interface mmg_cfg_if;
  logic valid;
  logic ready;
  logic clamp_negative;

  modport source (output valid, clamp_negative, input ready);
  modport sink   (input valid, clamp_negative, output ready);
endinterface : mmg_cfg_if
`default_nettype wire

/* hdl/minmax_gray_normalizer.sv */
// Top level: min/max gray normalizer (front end, queue, scaler back end).
// Scan items are taken one per cycle while the queue has room; no result.
// Convert items: a saturated or flat item goes from pop straight to the hold
// state and the output register; an in-range item passes pop, the 8-step serial
// scaler, correction and output load. The back end takes one convert item at a time.
// Reset (rst_ni low, asynchronous) clears min/max, clamp mode and the queue.
`default_nettype none
module minmax_gray_normalizer #(
  parameter int unsigned SAMPLE_BITS = mmg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mmg_cfg_if.sink   cfg_i,
  mmg_in_if.sink    in_i,
  mmg_out_if.source out_o
);

  localparam int unsigned ENTRY_BITS = mmg_pkg::KIND_BITS + 2 * SAMPLE_BITS;

  logic                  push, pop, full, empty;
  logic [ENTRY_BITS-1:0] push_data, pop_data;
  logic                  in_ready;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  mmg_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_i.valid),
    .cfg_clamp_i   (cfg_i.clamp_negative),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_ready),
    .operation_i   (in_i.operation),
    .frame_start_i (in_i.frame_start),
    .sample_i      (in_i.sample),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (full)
  );

  mmg_queue #(
    .DATA_BITS (ENTRY_BITS),
    .DEPTH     (mmg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  mmg_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .pop_data_i   (pop_data),
    .pop_o        (pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .level_o      (out_o.level),
    .flat_range_o (out_o.flat_range)
  );

endmodule : minmax_gray_normalizer
`default_nettype wire

/* hdl/mmg_front.sv */
// Front end: clamps samples, tracks running min/max, classifies convert items.
`default_nettype none
module mmg_front #(
  parameter int unsigned SAMPLE_BITS = mmg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_clamp_i,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          operation_i,
  input  wire logic                          frame_start_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  // queue push
  output logic                               push_o,
  output logic [mmg_pkg::KIND_BITS+2*SAMPLE_BITS-1:0] push_data_o,
  input  wire logic                          full_i
);

  logic                          clamp_q;
  logic signed [SAMPLE_BITS-1:0] min_q, min_d;
  logic signed [SAMPLE_BITS-1:0] max_q, max_d;
  logic signed [SAMPLE_BITS-1:0] v;
  logic signed [SAMPLE_BITS-1:0] base_min, base_max;
  logic [SAMPLE_BITS:0]          diff_d, diff_r;
  mmg_pkg::kind_e                kind;
  logic                          accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Negative clamp
  always_comb begin
    v = sample_i;
    if (clamp_q && sample_i[SAMPLE_BITS-1]) begin
      v = '0;
    end
  end

  // Scan: optional frame restart, then fold the sample in
  always_comb begin
    base_min = min_q;
    base_max = max_q;
    if (frame_start_i) begin
      base_min = '0;
      base_max = v;
    end
    min_d = (v < base_min) ? v : base_min;
    max_d = (base_max < v) ? v : base_max;
  end

  // Convert: classify against the current range
  always_comb begin
    diff_d = {v[SAMPLE_BITS-1], v} - {min_q[SAMPLE_BITS-1], min_q};
    diff_r = {max_q[SAMPLE_BITS-1], max_q} - {min_q[SAMPLE_BITS-1], min_q};
    priority if (!(min_q < max_q)) begin
      kind = mmg_pkg::KIND_FLAT;
    end else if (v < min_q) begin
      kind = mmg_pkg::KIND_LOW;
    end else if (!(v < max_q)) begin
      kind = mmg_pkg::KIND_HIGH;
    end else begin
      kind = mmg_pkg::KIND_DIV;
    end
  end

  assign push_o      = accept && operation_i;
  assign push_data_o = {kind, diff_d[SAMPLE_BITS-1:0], diff_r[SAMPLE_BITS-1:0]};

  // Range state and configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_q <= 1'b0;
      min_q   <= '0;
      max_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        clamp_q <= cfg_clamp_i;
      end
      if (accept && !operation_i) begin
        min_q <= min_d;
        max_q <= max_d;
      end
    end
  end

endmodule : mmg_front
`default_nettype wire

/* hdl/mmg_queue.sv */
// Small FIFO decoupling the front end from the scaler.
`default_nettype none
module mmg_queue #(
  parameter int unsigned DATA_BITS = 2 * mmg_pkg::SAMPLE_BITS_DEF + mmg_pkg::KIND_BITS,
  parameter int unsigned DEPTH     = mmg_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire logic [DATA_BITS-1:0] push_data_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic [DATA_BITS-1:0]      pop_data_o,
  output logic                      empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_BITS-1:0] mem_q [DEPTH];
  logic [AW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [AW:0]          count_q;

  assign full_o     = (count_q == (AW+1)'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule : mmg_queue
`default_nettype wire

/* hdl/mmg_back.sv */
// Back end: bit-serial floor(255*d/r) scaler and output register.
`default_nettype none
module mmg_back #(
  parameter int unsigned SAMPLE_BITS = mmg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // queue pop
  input  wire logic                          empty_i,
  input  wire logic [mmg_pkg::KIND_BITS+2*SAMPLE_BITS-1:0] pop_data_i,
  output logic                               pop_o,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [mmg_pkg::LEVEL_BITS-1:0]     level_o,
  output logic                               flat_range_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIX,
    S_HOLD
  } state_e;

  state_e                           state_q;
  logic [mmg_pkg::STEP_BITS-1:0]    step_q;
  logic [SAMPLE_BITS-1:0]           d_q, r_q, rem_q;
  logic [mmg_pkg::LEVEL_BITS-1:0]   q_q, res_level_q;
  logic                             res_flat_q;
  logic                             out_valid_q;
  logic [mmg_pkg::LEVEL_BITS-1:0]   level_q;
  logic                             flat_q;

  mmg_pkg::kind_e                   pop_kind;
  logic [SAMPLE_BITS-1:0]           pop_d, pop_r;
  logic [SAMPLE_BITS-1:0]           gap;
  logic                             take;
  logic                             out_free;

  assign pop_kind = mmg_pkg::kind_e'(pop_data_i[2*SAMPLE_BITS +: mmg_pkg::KIND_BITS]);
  assign pop_d    = pop_data_i[SAMPLE_BITS +: SAMPLE_BITS];
  assign pop_r    = pop_data_i[0 +: SAMPLE_BITS];

  assign pop_o    = (state_q == S_IDLE) && !empty_i;
  assign out_free = !out_valid_q || out_ready_i;

  // One quotient bit per step: compare rem against r - rem
  assign gap  = r_q - rem_q;
  assign take = (rem_q >= gap);

  assign out_valid_o  = out_valid_q;
  assign level_o      = level_q;
  assign flat_range_o = flat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      d_q         <= '0;
      r_q         <= '0;
      rem_q       <= '0;
      q_q         <= '0;
      res_level_q <= '0;
      res_flat_q  <= 1'b0;
      out_valid_q <= 1'b0;
      level_q     <= '0;
      flat_q      <= 1'b0;
    end else begin
      // output register drains on handshake, unless reloaded below
      if (out_valid_q && out_ready_i && (state_q != S_HOLD)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            d_q        <= pop_d;
            r_q        <= pop_r;
            rem_q      <= pop_d;
            q_q        <= '0;
            step_q     <= '0;
            res_flat_q <= (pop_kind == mmg_pkg::KIND_FLAT);
            unique case (pop_kind)
              mmg_pkg::KIND_FLAT: begin
                res_level_q <= '0;
                state_q     <= S_HOLD;
              end
              mmg_pkg::KIND_LOW: begin
                res_level_q <= '0;
                state_q     <= S_HOLD;
              end
              mmg_pkg::KIND_HIGH: begin
                res_level_q <= mmg_pkg::LEVEL_MAX;
                state_q     <= S_HOLD;
              end
              default: begin
                state_q <= S_DIV;
              end
            endcase
          end
        end
        S_DIV: begin
          q_q   <= {q_q[mmg_pkg::LEVEL_BITS-2:0], take};
          rem_q <= take ? (rem_q - gap) : {rem_q[SAMPLE_BITS-2:0], 1'b0};
          step_q <= step_q + 1'b1;
          if (step_q == mmg_pkg::STEP_BITS'(mmg_pkg::STEP_COUNT - 1)) begin
            state_q <= S_FIX;
          end
        end
        S_FIX: begin
          // 256*d = q*r + rem, so 255*d = q*r + rem - d
          res_level_q <= (rem_q < d_q) ? (q_q - 1'b1) : q_q;
          state_q     <= S_HOLD;
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            level_q     <= res_level_q;
            flat_q      <= res_flat_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule : mmg_back
`default_nettype wire

/* hdl/mmg_checker.sv */
// Port-level checks for the min/max gray normalizer, bound to the top level.
`default_nettype none
module mmg_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           cfg_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [mmg_pkg::LEVEL_BITS-1:0] out_level,
  input wire logic                           out_flat
);

  // Result held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // Stalled payload stable
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_level) && $stable(out_flat))
    else $error("result item changed while stalled");

  // A flat range always reports level zero
  a_flat_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_flat |-> out_level == '0)
    else $error("flat range with nonzero level");

  // Configuration is always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready)
    else $error("configuration port not ready");

  // No result in the cycle after reset is seen
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid)
    else $error("result item shown during reset");

endmodule : mmg_checker

bind minmax_gray_normalizer mmg_checker u_mmg_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .cfg_ready (cfg_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_level (out_o.level),
  .out_flat  (out_o.flat_range)
);
`default_nettype wire
